// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the cosine transform block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/ect_pkg.sv
// Shared types and constants of the even cosine transform block.
// Used by the divider, the cosine table and the top level; depends on nothing.
package ect_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int INDEX_W     = 12;
    localparam int VALUE_W     = 56;
    localparam int COS_W       = 24;
    localparam int COUNT_REG_W = 11;
    localparam int HALF_REG_W  = 12;
    localparam int SPAN_W      = 24;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_COUNT = 2'd0,
        REG_HALF_OUTPUTS = 2'd1,
        REG_SPAN_WIDTH   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/even_cosine_transform.sv
// Even cosine transform: a store of samples, a sequencer, one shared divider,
// a cosine table and one multiply-accumulate path. Uses ect_pkg, ect_divider
// and ect_cos_rom.
//
// A load transaction (tuser op = 0) writes the next sample.
// A query transaction (op = 1) with out_index below 2*half_outputs returns the
// sum over sample_count stored samples of sample times the cosine of the
// mirrored phase. The phase step is set up by the bit-serial divider, run twice per
// query on a dividend of DVD_W = clog2(MAX_SAMPLES+1) + clog2(MAX_OUTPUTS/2+1) +
// 14 + COS_TABLE_BITS bits, and the single multiply-accumulate takes one sample
// per cycle. A query whose index is out of the grid returns nothing. The input
// is not ready while a query is at work. Configuration writes are always
// accepted.
module even_cosine_transform import ect_pkg::*; #(
    parameter int MAX_SAMPLES    = 1024,
    parameter int MAX_OUTPUTS    = 4096,
    parameter int COS_TABLE_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample[23:0], out_index[35:24], zero fill
    input  logic [0:0]            s_tuser,   // op[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // value[55:0], index[67:56], zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int B       = COS_TABLE_BITS;
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CW      = $clog2(MAX_SAMPLES + 1);
    localparam int MAXH    = MAX_OUTPUTS / 2;
    localparam int HW      = $clog2(MAXH + 1);
    localparam int DEN_W   = CW + HW + 13;
    localparam int PROD_W  = SPAN_W + HW;
    localparam int DVD_W   = DEN_W + B + 1;
    localparam int DSR_W   = DEN_W + 1;
    localparam int MAC_W   = SAMPLE_W + COS_W + 1;
    localparam int ACC_W   = MAC_W + ADDR_W + 1;
    localparam int QW      = ACC_W + 1 - 7;
    localparam int XW      = (QW > VALUE_W ? QW : VALUE_W) + 1;
    localparam int QUARTER = 1 << (B - 2);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W, S_RUN, S_DRAIN
    } state_t;

    state_t state_reg;

    logic [COUNT_REG_W-1:0] count_raw_reg;
    logic [HALF_REG_W-1:0]  half_raw_reg;
    logic [SPAN_W-1:0]      span_reg;

    logic [CW-1:0] count_eff;
    logic [HW-1:0] half_eff;

    always_comb begin
        if (count_raw_reg == '0) begin
            count_eff = CW'(1);
        end else if (32'(count_raw_reg) > 32'(MAX_SAMPLES)) begin
            count_eff = CW'(MAX_SAMPLES);
        end else begin
            count_eff = CW'(count_raw_reg);
        end
        if (half_raw_reg == '0) begin
            half_eff = HW'(1);
        end else if (32'(half_raw_reg) > 32'(MAXH)) begin
            half_eff = HW'(MAXH);
        end else begin
            half_eff = HW'(half_raw_reg);
        end
    end

    logic                s_op;
    logic [SAMPLE_W-1:0] s_sample;
    logic [INDEX_W-1:0]  s_index;
    logic                s_acc;
    logic                in_grid;
    logic [HW-1:0]       m_dist;

    always_comb begin
        s_op     = s_tuser[0];
        s_sample = s_tdata[SAMPLE_W-1:0];
        s_index  = s_tdata[SAMPLE_W +: INDEX_W];
        s_acc    = s_tvalid && s_tready;
        in_grid  = 32'(s_index) < (32'(half_eff) << 1);
        if (32'(s_index) <= 32'(half_eff)) begin
            m_dist = HW'(32'(half_eff) - 32'(s_index));
        end else begin
            m_dist = HW'(32'(s_index) - 32'(half_eff));
        end
    end

    logic [SAMPLE_W-1:0] mem [0:MAX_SAMPLES-1];
    logic [ADDR_W-1:0]   ptr_reg;
    logic [ADDR_W:0]     ptr_inc;

    assign ptr_inc = {1'b0, ptr_reg} + 1'b1;

    logic [INDEX_W-1:0] j_reg;
    logic [HW-1:0]      m_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]   step_reg;
    logic [B-1:0]       qs_reg, qi_reg;
    logic [DSR_W-1:0]   rs_reg, ri_reg;
    logic [ADDR_W-1:0]  i_reg;

    div_ctrl_t        div_ctrl;
    div_stat_t        div_stat;
    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DSR_W-1:0] div_dsr, div_rem;

    always_comb begin
        div_ctrl.start = (state_reg == S_DIV1) || (state_reg == S_DIV2);
        if (state_reg == S_DIV2) begin
            div_dvd = {step_reg, {(B + 1){1'b0}}};
            div_dsr = {den_reg, 1'b0};
        end else begin
            div_dvd = DVD_W'(prod_reg);
            div_dsr = DSR_W'(den_reg);
        end
    end

    ect_divider #(
        .DVD_W(DVD_W),
        .DSR_W(DSR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .stat     (div_stat),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // Phase index advance: the remainder against 2*den carries into the index.
    logic [DSR_W:0] ri_sum;
    logic           ri_carry;

    always_comb begin
        ri_sum   = {1'b0, ri_reg} + {1'b0, rs_reg};
        ri_carry = ri_sum >= {1'b0, den_reg, 1'b0};
    end

    logic [B:0]   qi_ext;
    logic [B-2:0] rom_addr;
    logic         neg_issue;

    always_comb begin
        qi_ext = {1'b0, qi_reg};
        if (qi_ext <= (B + 1)'(QUARTER)) begin
            rom_addr  = (B - 1)'(qi_ext);
            neg_issue = 1'b0;
        end else if (qi_ext <= (B + 1)'(2 * QUARTER)) begin
            rom_addr  = (B - 1)'((B + 1)'(2 * QUARTER) - qi_ext);
            neg_issue = 1'b1;
        end else if (qi_ext <= (B + 1)'(3 * QUARTER)) begin
            rom_addr  = (B - 1)'(qi_ext - (B + 1)'(2 * QUARTER));
            neg_issue = 1'b1;
        end else begin
            rom_addr  = (B - 1)'((B + 1)'(4 * QUARTER) - qi_ext);
            neg_issue = 1'b0;
        end
    end

    logic [COS_W-1:0] cos_mag;

    ect_cos_rom #(
        .TBL_BITS(B)
    ) u_rom (
        .aclk(aclk),
        .addr(rom_addr),
        .data(cos_mag)
    );

    logic                 issue;
    logic                 v1_reg, v2_reg, neg_reg;
    logic [SAMPLE_W-1:0]  rd_reg;
    logic signed [COS_W:0]   cos_s;
    logic signed [MAC_W-1:0] mac_reg;
    logic signed [ACC_W-1:0] acc_reg;

    assign issue = state_reg == S_RUN;
    assign cos_s = neg_reg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

    always_ff @(posedge aclk) begin
        rd_reg  <= mem[i_reg];
        neg_reg <= neg_issue;
        mac_reg <= MAC_W'($signed(rd_reg) * cos_s);
        if (s_acc && s_op == OP_LOAD) begin
            mem[ptr_reg] <= s_sample;
        end
    end

    // Rounding half up to 39 fraction bits, then saturation to 56 bits.
    logic signed [ACC_W:0]   v_rnd;
    logic signed [QW-1:0]    q_rnd;
    logic signed [XW-1:0]    q_ext;
    logic [VALUE_W-1:0]      value_sat;
    localparam logic signed [XW-1:0] SAT_HI = XW'({1'b0, {(VALUE_W - 1){1'b1}}});
    localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);

    always_comb begin
        v_rnd = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W + 1)'(64);
        q_rnd = QW'(v_rnd >>> 7);
        q_ext = XW'(q_rnd);
        if (q_ext > SAT_HI) begin
            value_sat = VALUE_W'(SAT_HI);
        end else if (q_ext < SAT_LO) begin
            value_sat = VALUE_W'(SAT_LO);
        end else begin
            value_sat = VALUE_W'(q_ext);
        end
    end

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_load;

    assign out_load = (state_reg == S_DRAIN) && !v1_reg && !v2_reg &&
                      (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_raw_reg <= COUNT_REG_W'(1);
            half_raw_reg  <= HALF_REG_W'(1);
            span_reg      <= SPAN_W'(4096);
            ptr_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SAMPLE_COUNT: count_raw_reg <= cfg_data[COUNT_REG_W-1:0];
                    REG_HALF_OUTPUTS: half_raw_reg  <= cfg_data[HALF_REG_W-1:0];
                    REG_SPAN_WIDTH:   span_reg      <= cfg_data[SPAN_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                acc_reg <= acc_reg + ACC_W'(mac_reg);
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_op == OP_LOAD) begin
                        if ((ADDR_W + 1)'(ptr_inc) >= (ADDR_W + 1)'(count_eff)) begin
                            ptr_reg <= '0;
                        end else begin
                            ptr_reg <= ptr_inc[ADDR_W-1:0];
                        end
                    end else if (s_acc && in_grid) begin
                        j_reg     <= s_index;
                        m_reg     <= m_dist;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    den_reg   <= DEN_W'({(CW + HW)'(count_eff * half_eff), 13'b0});
                    prod_reg  <= PROD_W'(span_reg * m_reg);
                    acc_reg   <= '0;
                    state_reg <= S_DIV1;
                end
                S_DIV1: state_reg <= S_DIV1W;
                S_DIV1W: begin
                    if (div_stat.done) begin
                        step_reg  <= DEN_W'(div_rem);
                        state_reg <= S_DIV2;
                    end
                end
                S_DIV2: state_reg <= S_DIV2W;
                S_DIV2W: begin
                    if (div_stat.done) begin
                        qs_reg    <= div_quo[B-1:0];
                        rs_reg    <= div_rem;
                        qi_reg    <= '0;
                        ri_reg    <= DSR_W'(den_reg);
                        i_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (ri_carry) begin
                        ri_reg <= DSR_W'(ri_sum - {1'b0, den_reg, 1'b0});
                        qi_reg <= qi_reg + qs_reg + B'(1);
                    end else begin
                        ri_reg <= ri_sum[DSR_W-1:0];
                        qi_reg <= qi_reg + qs_reg;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == ADDR_W'(count_eff - 1'b1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (out_load) begin
                        m_tdata_reg  <= M_TDATA_W'({j_reg, value_sat});
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

// File: hdl/ect_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses the control and status structs of ect_pkg.
module ect_divider import ect_pkg::*; #(
    parameter int DVD_W = 48,
    parameter int DSR_W = 36
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctrl_t        ctrl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient,
    output logic [DSR_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, quo_reg;
    logic [DSR_W-1:0] dsr_reg, rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DSR_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/ect_cos_rom.sv
// Quarter-wave cosine table in Q1.23 with a registered read port.
// Contents are built at elaboration; uses COS_W from ect_pkg.
module ect_cos_rom import ect_pkg::*; #(
    parameter int TBL_BITS = 12
) (
    input  logic                  aclk,
    input  logic [TBL_BITS-2:0]   addr,
    output logic [COS_W-1:0]      data
);

    localparam int QUARTER = 1 << (TBL_BITS - 2);

    typedef logic [COS_W-1:0] rom_t [0:QUARTER];

    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned dsr);
        longint unsigned quo, rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dsr) begin
                rem    = rem - dsr;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic rom_t build_rom();
        rom_t            rom;
        longint unsigned x, x2, term;
        longint          sum, r;
        for (int n = 0; n <= QUARTER; n++) begin
            x    = (64'd26986075409 * longint'(n) + (64'd1 << TBL_BITS)) >> (TBL_BITS + 1);
            x2   = (x * x + (64'd1 << 30)) >> 31;
            term = 64'd1 << 31;
            sum  = longint'(term);
            for (int k = 0; k < 12; k++) begin
                term = div_u64((term * x2) >> 31, 64'((2 * k + 1) * (2 * k + 2)));
                if ((k & 1) == 0) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 128) >>> 8;
            if (r > 8388608) begin
                r = 8388608;
            end
            rom[n] = COS_W'(r);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic [COS_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= COS_ROM[addr];
    end

    assign data = data_reg;

endmodule

// File: hdl/ect_checker.sv
// Port-level checker for the even cosine transform, bound to the top level.
// Uses the macros of assert_macros.svh and the codes of ect_pkg.
`include "assert_macros.svh"

module ect_checker import ect_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 cfg_ready
);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_NEXT(a_load_ready, aclk, aresetn, s_tvalid && s_tready && s_tuser[0] == OP_LOAD, s_tready)
    `ASSERT_SAME(a_result_after_work, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))
    `ASSERT_SAME(a_cfg_ready, aclk, aresetn, 1'b1, cfg_ready)

endmodule

bind even_cosine_transform ect_checker u_ect_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);

// File: tb/ect_checker.sv
`timescale 1ns / 100ps
// Checker for the even cosine transform: watches the sample, result and register channels,
// predicts each result and compares it with what the block returns. Uses ect_pkg.
module ect_scoreboard import ect_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } cos_result_t;

    logic signed [SAMPLE_W-1:0] samples [1024];
    int                         quarter_wave [1025];
    int unsigned                wr_ptr;
    logic [COUNT_REG_W-1:0]     count_reg;
    logic [HALF_REG_W-1:0]      half_reg;
    logic [SPAN_W-1:0]          span_reg;
    cos_result_t                awaiting [$];

    initial begin
        longint unsigned x, x2, term;
        longint          acc, r;
        fail_count = 0;
        pending    = 0;
        for (int n = 0; n <= 1024; n++) begin
            x    = (64'd26986075409 * n + 64'd4096) >> 13;
            x2   = (x * x + (64'd1 << 30)) >> 31;
            term = 64'd1 << 31;
            acc  = longint'(term);
            for (int k = 0; k < 12; k++) begin
                term = ((term * x2) >> 31) / longint'((2 * k + 1) * (2 * k + 2));
                if (k % 2 == 0) begin
                    acc -= longint'(term);
                end else begin
                    acc += longint'(term);
                end
            end
            if (acc < 0) acc = 0;
            r = (acc + 128) >>> 8;
            if (r > 8388608) r = 8388608;
            quarter_wave[n] = int'(r);
        end
    end

    function automatic int cos_at(longint unsigned pos);
        int unsigned i;
        i = int'(pos & 64'hFFF);
        if (i <= 1024) return quarter_wave[i];
        if (i <= 2048) return -quarter_wave[2048 - i];
        if (i <= 3072) return -quarter_wave[i - 2048];
        return quarter_wave[4096 - i];
    endfunction

    function automatic int unsigned used_count();
        if (count_reg == 0) return 1;
        return (count_reg > 1024) ? 1024 : count_reg;
    endfunction

    function automatic logic [VALUE_W-1:0] transform_value(int unsigned j);
        int unsigned     cnt, half, mirror;
        longint unsigned den, step, phase;
        longint          acc, v;
        cnt    = used_count();
        half   = (half_reg == 0) ? 1 : ((half_reg > 2048) ? 2048 : half_reg);
        mirror = (j <= half) ? half - j : j - half;
        den    = 64'd4096 * cnt * 2 * half;
        step   = (longint'(span_reg) * mirror) % den;
        phase  = 0;
        acc    = 0;
        for (int i = 0; i < cnt; i++) begin
            acc += longint'(samples[i]) * longint'(cos_at(((phase << 13) + den) / (2 * den)));
            phase += step;
            if (phase >= den) phase -= den;
        end
        v = (acc + 64) >>> 7;
        return v[VALUE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        cos_result_t got, want;
        int unsigned j, half;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            wr_ptr    = 0;
            count_reg = COUNT_REG_W'(1);
            half_reg  = HALF_REG_W'(1);
            span_reg  = SPAN_W'(4096);
            awaiting.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SAMPLE_COUNT: count_reg = cfg_data[COUNT_REG_W-1:0];
                    REG_HALF_OUTPUTS: half_reg = cfg_data[HALF_REG_W-1:0];
                    REG_SPAN_WIDTH:   span_reg = cfg_data[SPAN_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser[0]) == OP_LOAD) begin
                    samples[wr_ptr % 1024] = s_tdata[SAMPLE_W-1:0];
                    wr_ptr = (wr_ptr + 1 >= used_count()) ? 0 : wr_ptr + 1;
                end else begin
                    j    = 32'(s_tdata[SAMPLE_W +: INDEX_W]);
                    half = (half_reg == 0) ? 1 : ((half_reg > 2048) ? 2048 : half_reg);
                    if (j < 2 * half) begin
                        want.value = transform_value(j);
                        want.index = INDEX_W'(j);
                        awaiting.push_back(want);
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[VALUE_W+INDEX_W-1:0];
                if (awaiting.size() == 0) begin
                    $error("unexpected result transaction, index %0d", got.index);
                    errs++;
                end else begin
                    want = awaiting.pop_front();
                    if (got.value !== want.value) begin
                        $error("value: expected %0d, actual %0d",
                               $signed(want.value), $signed(got.value));
                        errs++;
                    end
                    if (got.index !== want.index) begin
                        $error("index: expected %0d, actual %0d", want.index, got.index);
                        errs++;
                    end
                end
            end
        end
        fail_count <= fail_count + errs;
        pending    <= awaiting.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the even cosine transform testbench: clock, reset, directed and random stimulus
// with idle phases, and the verdict. Uses ect_pkg, even_cosine_transform and ect_scoreboard.
module tb import ect_pkg::*; ();

    localparam int SETTLE = 1300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int unsigned           tx_pct = 0;
    int unsigned           rx_pct = 0;
    int unsigned           load_ptr = 0;
    int unsigned           count_now = 1;
    int unsigned           half_now = 1;
    bit                    written [1024];

    even_cosine_transform dut (.*);

    ect_scoreboard u_scoreboard (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= (rx_pct == 0) || ($urandom_range(99) >= rx_pct);
    end

    task automatic send(op_t op, logic [SAMPLE_W-1:0] smp, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < tx_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, idx, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_LOAD) begin
            written[load_ptr % 1024] = 1'b1;
            load_ptr = (load_ptr + 1 >= count_now) ? 0 : load_ptr + 1;
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid  <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: count_now = (val[10:0] == 0) ? 1 :
                                          ((val[10:0] > 1024) ? 1024 : val[10:0]);
            REG_HALF_OUTPUTS: half_now = (val[11:0] == 0) ? 1 :
                                         ((val[11:0] > 2048) ? 2048 : val[11:0]);
            default: ;
        endcase
    endtask

    function automatic bit store_ready();
        for (int i = 0; i < count_now; i++) if (!written[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        int unsigned n_cnt, n_half;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(OP_LOAD, 24'h7FFFFF, 12'd0);
        send(OP_QUERY, 24'h0, 12'd0);
        send(OP_QUERY, 24'h0, 12'd1);
        send(OP_QUERY, 24'h0, 12'd2);
        write_reg(REG_SAMPLE_COUNT, 24'd4);
        write_reg(REG_HALF_OUTPUTS, 24'd3);
        write_reg(REG_SPAN_WIDTH, 24'd4096);
        send(OP_LOAD, 24'h800000, 12'd0);
        send(OP_LOAD, 24'h7FFFFF, 12'd0);
        send(OP_LOAD, 24'h000000, 12'd0);
        send(OP_LOAD, 24'h000001, 12'd0);
        send(OP_QUERY, 24'h0, 12'd0);
        send(OP_QUERY, 24'h0, 12'd3);
        send(OP_QUERY, 24'h0, 12'd5);
        send(OP_QUERY, 24'h0, 12'd6);
        send(OP_QUERY, 24'h0, 12'd4095);
        send(OP_LOAD, 24'h123456, 12'd0);
        send(OP_LOAD, 24'hFEDCBA, 12'd0);
        send(OP_LOAD, 24'h555555, 12'd0);
        write_reg(REG_SAMPLE_COUNT, 24'd2);
        send(OP_LOAD, 24'hAAAAAA, 12'd0);
        send(OP_QUERY, 24'h0, 12'd1);

        for (int ph = 0; ph < 8; ph++) begin
            tx_pct = (ph % 4 == 1) ? 45 : ((ph % 4 == 3) ? 8 : 0);
            rx_pct = (ph % 4 == 2) ? 45 : ((ph % 4 == 3) ? 8 : 0);
            case (ph)
                0: begin n_cnt = 0; n_half = 0; write_reg(REG_SPAN_WIDTH, 24'd0); end
                1: begin
                    n_cnt = 64; n_half = 4095;
                    write_reg(REG_SPAN_WIDTH, 24'hFFFFFF);
                end
                default: begin
                    n_cnt  = $urandom_range(1, 16);
                    n_half = $urandom_range(1, 40);
                    write_reg(REG_SPAN_WIDTH, CFG_DATA_W'($urandom()));
                end
            endcase
            write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(n_cnt));
            write_reg(REG_HALF_OUTPUTS, CFG_DATA_W'(n_half));
            while (!store_ready()) send(OP_LOAD, rand_sample(), INDEX_W'($urandom()));
            for (int it = 0; it < 40; it++) begin
                if ($urandom_range(99) < 40) begin
                    send(OP_LOAD, rand_sample(), INDEX_W'($urandom()));
                end else if ($urandom_range(99) < 85) begin
                    send(OP_QUERY, SAMPLE_W'($urandom()),
                         INDEX_W'($urandom_range(2 * half_now - 1)));
                end else begin
                    send(OP_QUERY, SAMPLE_W'($urandom()), INDEX_W'($urandom()));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
